// ===== rtl/tftprs_pkg.sv =====
// Shared types and constants for the TFTP read sender session.
// No dependencies; every other file in rtl/ uses this package.
package tftprs_pkg;

  localparam int BLOCK_W = 16;
  localparam int LEN_W   = 10;
  localparam int RETRY_W = 8;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;

  localparam logic [RETRY_W-1:0] RETRY_RESET = 8'd16;

  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_ACK    = 2'd1,
    OP_TICK   = 2'd2,
    OP_CANCEL = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_NEW     = 3'd0,
    ST_RESENT  = 3'd1,
    ST_NOTHING = 3'd2,
    ST_DONE    = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_CANCEL  = 3'd5,
    ST_IGNORED = 3'd6
  } status_e;

  // One input request
  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [BLOCK_W-1:0] ack_block;
    logic [LEN_W-1:0]   read_length;
  } item_t;

  // One result
  typedef struct packed {
    logic               send_data;
    logic [BLOCK_W-1:0] block_number;
    logic [LEN_W-1:0]   data_length;
    logic [STAT_W-1:0]  status;
  } result_t;

  // Handshake between the input stage and the result stage
  typedef struct packed {
    logic item_valid;  // input register holds a request
    logic slot_free;   // result register can take a new result this cycle
  } pipe_ctl_t;

endpackage

// ===== rtl/tftprs_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on tftprs_pkg for the field widths.
interface tftprs_req_if;
  logic                              valid;
  logic                              ready;
  logic [tftprs_pkg::OP_W-1:0]       operation;
  logic [tftprs_pkg::BLOCK_W-1:0]    ack_block;
  logic [tftprs_pkg::LEN_W-1:0]      read_length;

  modport source (output valid, output operation, output ack_block, output read_length,
                  input ready);
  modport sink   (input valid, input operation, input ack_block, input read_length,
                  output ready);
endinterface

interface tftprs_res_if;
  logic                              valid;
  logic                              ready;
  logic                              send_data;
  logic [tftprs_pkg::BLOCK_W-1:0]    block_number;
  logic [tftprs_pkg::LEN_W-1:0]      data_length;
  logic [tftprs_pkg::STAT_W-1:0]     status;

  modport source (output valid, output send_data, output block_number, output data_length,
                  output status, input ready);
  modport sink   (input valid, input send_data, input block_number, input data_length,
                  input status, output ready);
endinterface

// ===== rtl/tftprs_in_stage.sv =====
// Input register: captures one request and holds it until the session logic takes it.
// Depends on tftprs_pkg.
module tftprs_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  tftprs_pkg::item_t   item_i,
  input  logic                slot_free_i,
  output tftprs_pkg::pipe_ctl_t ctl_o,
  output tftprs_pkg::item_t   item_o
);
  import tftprs_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  take;

  // Request leaves the register when the result stage has room
  assign take    = valid_q && slot_free_i;
  assign ready_o = !valid_q || take;

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign ctl_o.item_valid = valid_q;
  assign ctl_o.slot_free  = slot_free_i;
  assign item_o           = item_q;

endmodule

// ===== rtl/tftprs_session.sv =====
// Session state and per-request decision logic of the TFTP read sender.
// Depends on tftprs_pkg; fed by tftprs_in_stage, drives tftprs_out_stage.
module tftprs_session #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tftprs_pkg::pipe_ctl_t              ctl_i,
  input  tftprs_pkg::item_t                  item_i,
  input  logic [tftprs_pkg::RETRY_W-1:0]     retry_limit_i,
  output logic                               fire_o,
  output tftprs_pkg::result_t                result_o
);
  import tftprs_pkg::*;

  localparam int CmpW = LEN_W + 1;
  localparam logic [CmpW-1:0] BlockLen = CmpW'(BLOCK_BYTES);

  logic               active_q,  active_d;
  logic [BLOCK_W-1:0] block_q,   block_d;
  logic [LEN_W-1:0]   length_q,  length_d;
  logic [RETRY_W-1:0] retries_q, retries_d;

  logic               fire;
  logic [LEN_W-1:0]   fetch_len;
  logic [RETRY_W-1:0] retries_dec;
  logic               send;
  status_e            status;

  assign fire = ctl_i.item_valid && ctl_i.slot_free;

  // Clamp the fetched length to one full block
  assign fetch_len = ({1'b0, item_i.read_length} > BlockLen) ? BlockLen[LEN_W-1:0]
                                                             : item_i.read_length;
  assign retries_dec = retries_q - RETRY_W'(1);

  // Decide the result and the next session state
  always_comb begin
    active_d  = active_q;
    block_d   = block_q;
    length_d  = length_q;
    retries_d = retries_q;
    send      = 1'b0;
    status    = ST_IGNORED;
    case (op_e'(item_i.operation))
      OP_START: begin
        if (!active_q) begin
          active_d  = 1'b1;
          block_d   = BLOCK_W'(1);
          length_d  = fetch_len;
          retries_d = retry_limit_i;
          send      = 1'b1;
          status    = ST_NEW;
        end
      end
      OP_ACK: begin
        if (active_q && item_i.ack_block == block_q) begin
          if ({1'b0, length_q} < BlockLen) begin
            active_d = 1'b0;
            status   = ST_DONE;
          end else begin
            block_d   = block_q + BLOCK_W'(1);
            length_d  = fetch_len;
            retries_d = retry_limit_i;
            send      = 1'b1;
            status    = ST_NEW;
          end
        end
      end
      OP_TICK: begin
        status = ST_NOTHING;
        if (active_q) begin
          if (retries_q == '0) begin
            active_d = 1'b0;
            status   = ST_TIMEOUT;
          end else begin
            retries_d = retries_dec;
            if (retries_dec[1:0] == 2'b00) begin
              send   = 1'b1;
              status = ST_RESENT;
            end
          end
        end
      end
      OP_CANCEL: begin
        if (active_q) begin
          active_d = 1'b0;
          status   = ST_CANCEL;
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  // Report the block after this request's update
  assign result_o.send_data    = send;
  assign result_o.block_number = block_d;
  assign result_o.data_length  = send ? length_d : '0;
  assign result_o.status       = status;
  assign fire_o                = fire;

  // Advance session state on each request taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      block_q   <= '0;
      length_q  <= '0;
      retries_q <= '0;
    end else if (fire) begin
      active_q  <= active_d;
      block_q   <= block_d;
      length_q  <= length_d;
      retries_q <= retries_d;
    end
  end

  // A completed, timed-out or cancelled session goes idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (status == ST_DONE || status == ST_TIMEOUT || status == ST_CANCEL)
    |=> !active_q)
    else $error("session still active after it ended");

  // A new block always opens or keeps an active session
  a_new_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && status == ST_NEW |=> active_q && block_q == $past(block_d))
    else $error("new block sent without active session");

  // Each live tick spends exactly one retry
  a_tick_spend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && op_e'(item_i.operation) == OP_TICK && active_q && retries_q != '0
    |=> retries_q == $past(retries_q) - RETRY_W'(1))
    else $error("tick did not spend one retry");

  // A sent packet never exceeds one block
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && send |-> {1'b0, result_o.data_length} <= BlockLen)
    else $error("data length above block size");

endmodule

// ===== rtl/tftprs_out_stage.sv =====
// Result register: holds one result until the downstream side takes it.
// Depends on tftprs_pkg.
module tftprs_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  tftprs_pkg::result_t result_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic                slot_free_o,
  output tftprs_pkg::result_t result_o
);
  import tftprs_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign slot_free_o = !valid_q || ready_i;

  // Hold valid until the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (slot_free_o) begin
      valid_q <= load_i;
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/tftp_read_sender_session_top.sv =====
// Top level of the TFTP read sender session: configuration register and stage wiring.
// Depends on tftprs_pkg, tftprs_if, tftprs_in_stage, tftprs_session, tftprs_out_stage.
//
//   channel  direction  handshake     payload
//   req_i    in         valid/ready   operation, ack_block, read_length
//   res_o    out        valid/ready   send_data, block_number, data_length, status
//   cfg      in         cfg_we_i      cfg_wdata_i (retry limit)
//
// One request per cycle sustained while res_o.ready stays high; a request passes through the
// input register, the session logic and then the result register before its result shows on res_o.
// Reset: session idle, block and length zero, retries zero, retry limit 16.
// A stalled result holds in its register; one further request waits in the input
// register, after which req_i.ready drops until the result is taken.
module tftp_read_sender_session_top #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tftprs_pkg::RETRY_W-1:0] cfg_wdata_i,
  tftprs_req_if.sink                     req_i,
  tftprs_res_if.source                   res_o
);
  import tftprs_pkg::*;

  logic [RETRY_W-1:0] retry_limit_q;
  item_t              in_item;
  item_t              held_item;
  pipe_ctl_t          ctl;
  logic               slot_free;
  logic               fire;
  result_t            next_result;
  result_t            out_result;

  // Retry limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RETRY_RESET;
    end else if (cfg_we_i) begin
      retry_limit_q <= cfg_wdata_i;
    end
  end

  assign in_item.operation   = req_i.operation;
  assign in_item.ack_block   = req_i.ack_block;
  assign in_item.read_length = req_i.read_length;

  tftprs_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (req_i.valid),
    .ready_o     (req_i.ready),
    .item_i      (in_item),
    .slot_free_i (slot_free),
    .ctl_o       (ctl),
    .item_o      (held_item)
  );

  tftprs_session #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_session (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .item_i        (held_item),
    .retry_limit_i (retry_limit_q),
    .fire_o        (fire),
    .result_o      (next_result)
  );

  tftprs_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (next_result),
    .valid_o     (res_o.valid),
    .ready_i     (res_o.ready),
    .slot_free_o (slot_free),
    .result_o    (out_result)
  );

  assign res_o.send_data    = out_result.send_data;
  assign res_o.block_number = out_result.block_number;
  assign res_o.data_length  = out_result.data_length;
  assign res_o.status       = out_result.status;

endmodule
